@@ design/jpeg_bit_reader_unstuffing_defines.svh @@
// ---------------------------------------------------------------------------
// JPEG bit reader assertion macros
// Assertion forms used by the bit reader sequencer.
// ---------------------------------------------------------------------------
`ifndef JPEG_BIT_READER_UNSTUFFING_DEFINES_SVH
`define JPEG_BIT_READER_UNSTUFFING_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JBR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define JBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/jbr_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JPEG bit reader package
// Field widths, command codes and the word types shared by the modules.
// ---------------------------------------------------------------------------
package jbr_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;
  localparam int BYTE_W  = 8;

  localparam logic              CMD_LOAD   = 1'b0;
  localparam logic              CMD_READ   = 1'b1;
  localparam logic [BYTE_W-1:0] STUFF_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;

  typedef struct packed {
    logic               command;
    logic [BYTE_W-1:0]  data_byte;
    logic [COUNT_W-1:0] bit_count;
    logic               discard_stuffing;
  } jbr_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] bits_read;
    logic               load_dropped;
    logic               stream_empty;
  } jbr_result_t;

endpackage

@@ design/jbr_store.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JPEG bit reader byte store
// Ring store of bytes with one write port and one registered read port.
// ---------------------------------------------------------------------------
module jbr_store
  import jbr_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/jbr_seq.sv @@
`timescale 1ns / 1ps
`include "jpeg_bit_reader_unstuffing_defines.svh"
// ---------------------------------------------------------------------------
// JPEG bit reader sequencer
// Runs loads and reads on the byte store, a read taking one byte per cycle.
// ---------------------------------------------------------------------------
module jbr_seq
  import jbr_pkg::*;
#(
  parameter int BUFFER_BYTES  = 4096,
  parameter int MAX_READ_BITS = 32,
  parameter int AW            = 12,
  parameter int HW            = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  jbr_item_t         item,
  output logic              res_valid,
  input  logic              res_take,
  output jbr_result_t       res,
  output logic              mem_wr_en,
  output logic [AW-1:0]     mem_wr_addr,
  output logic [BYTE_W-1:0] mem_wr_data,
  output logic [AW-1:0]     mem_rd_addr,
  input  logic [BYTE_W-1:0] mem_rd_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BYTE,
    S_PUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]      wr_idx_r, wr_idx_nxt;
  logic [HW-1:0]      held_r, held_nxt;
  logic [2:0]         bitpos_r, bitpos_nxt;
  logic [BYTE_W-1:0]  prev_r, prev_nxt;
  logic               prev_vld_r, prev_vld_nxt;
  logic               disc_r, disc_nxt;
  logic [COUNT_W-1:0] want_r, want_nxt;
  logic [COUNT_W-1:0] got_r, got_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic               drop_r, drop_nxt;

  logic               in_acc;
  logic               full;
  logic [COUNT_W-1:0] want_sat;
  logic               skip;
  logic [3:0]         avail;
  logic [COUNT_W-1:0] remain;
  logic [3:0]         take;
  logic [BYTE_W-1:0]  aligned;
  logic [VALUE_W-1:0] chunk;
  logic [4:0]         shamt;
  logic               ends;
  logic [COUNT_W-1:0] got_sum;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
    next_slot = (idx == AW'(BUFFER_BYTES - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign full     = (held_r == HW'(BUFFER_BYTES));
  assign want_sat = (item.bit_count > COUNT_W'(MAX_READ_BITS)) ?
                    COUNT_W'(MAX_READ_BITS) : item.bit_count;

  assign skip    = disc_r && prev_vld_r && (bitpos_r == 3'd0) &&
                   (prev_r == STUFF_BYTE) && (mem_rd_data == ZERO_BYTE);
  assign avail   = 4'd8 - {1'b0, bitpos_r};
  assign remain  = want_r - got_r;
  assign take    = (remain < {2'b00, avail}) ? remain[3:0] : avail;
  assign aligned = mem_rd_data << bitpos_r;
  assign chunk   = {{(VALUE_W-BYTE_W){1'b0}}, aligned} >> (4'd8 - take);
  assign shamt   = 5'(remain - {2'b00, take});
  assign ends    = (({1'b0, bitpos_r} + take) == 4'd8);
  assign got_sum = got_r + {2'b00, take};

  always_comb begin
    state_nxt    = state_r;
    rd_idx_nxt   = rd_idx_r;
    wr_idx_nxt   = wr_idx_r;
    held_nxt     = held_r;
    bitpos_nxt   = bitpos_r;
    prev_nxt     = prev_r;
    prev_vld_nxt = prev_vld_r;
    disc_nxt     = disc_r;
    want_nxt     = want_r;
    got_nxt      = got_r;
    value_nxt    = value_r;
    drop_nxt     = drop_r;
    mem_wr_en    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          got_nxt   = '0;
          value_nxt = '0;
          drop_nxt  = 1'b0;
          state_nxt = S_PUT;
          if (item.command == CMD_LOAD) begin
            if (full) begin
              drop_nxt = 1'b1;
            end else begin
              mem_wr_en  = 1'b1;
              wr_idx_nxt = next_slot(wr_idx_r);
              held_nxt   = held_r + 1'b1;
            end
          end else begin
            want_nxt = want_sat;
            disc_nxt = item.discard_stuffing;
            if ((want_sat != '0) && (held_r != '0)) begin
              state_nxt = S_BYTE;
            end
          end
        end
      end
      S_BYTE: begin
        if (skip) begin
          prev_nxt     = mem_rd_data;
          prev_vld_nxt = 1'b1;
          rd_idx_nxt   = next_slot(rd_idx_r);
          held_nxt     = held_r - 1'b1;
          bitpos_nxt   = 3'd0;
          if (held_r == HW'(1)) begin
            state_nxt = S_PUT;
          end
        end else begin
          value_nxt = value_r | (chunk << shamt);
          got_nxt   = got_sum;
          if (ends) begin
            prev_nxt     = mem_rd_data;
            prev_vld_nxt = 1'b1;
            rd_idx_nxt   = next_slot(rd_idx_r);
            held_nxt     = held_r - 1'b1;
            bitpos_nxt   = 3'd0;
          end else begin
            bitpos_nxt = 3'(bitpos_r + take[2:0]);
          end
          if ((got_sum == want_r) || (ends && (held_r == HW'(1)))) begin
            state_nxt = S_PUT;
          end
        end
      end
      S_PUT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rd_idx_r   <= '0;
      wr_idx_r   <= '0;
      held_r     <= '0;
      bitpos_r   <= '0;
      prev_r     <= '0;
      prev_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_idx_r   <= rd_idx_nxt;
      wr_idx_r   <= wr_idx_nxt;
      held_r     <= held_nxt;
      bitpos_r   <= bitpos_nxt;
      prev_r     <= prev_nxt;
      prev_vld_r <= prev_vld_nxt;
    end
    disc_r  <= disc_nxt;
    want_r  <= want_nxt;
    got_r   <= got_nxt;
    value_r <= value_nxt;
    drop_r  <= drop_nxt;
  end

  assign mem_wr_addr = wr_idx_r;
  assign mem_wr_data = item.data_byte;
  assign mem_rd_addr = rd_idx_nxt;

  assign res_valid        = (state_r == S_PUT);
  assign res.value        = value_r;
  assign res.bits_read    = got_r;
  assign res.load_dropped = drop_r;
  assign res.stream_empty = (held_r == '0);

  `JBR_ASSERT_IMPL(a_held_bound, clk, rst_n, 1'b1, held_r <= HW'(BUFFER_BYTES), "held count above store size")
  `JBR_ASSERT_IMPL(a_bitpos_held, clk, rst_n, bitpos_r != 3'd0, held_r != '0, "partial byte with empty store")
  `JBR_ASSERT_IMPL(a_byte_work, clk, rst_n, state_r == S_BYTE, (got_r < want_r) && (held_r != '0), "byte step with nothing left to do")
  `JBR_ASSERT_NEXT(a_load_count, clk, rst_n, in_acc && (item.command == CMD_LOAD) && !full, held_r == $past(held_r) + 1'b1, "accepted load did not grow the store")

endmodule

@@ design/jpeg_bit_reader_unstuffing.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JPEG bit reader with byte unstuffing
// Byte ring store with an MSB-first bit reader that drops stuffed zero bytes.
// ---------------------------------------------------------------------------
// Each input word is a load (append data_byte to the store) or a read (take
// up to MAX_READ_BITS bits, MSB first, skipping a 0x00 after a consumed 0xFF
// when discard_stuffing is set). Every input word yields one result word.
// A load goes straight from acceptance to its result. A read steps through
// each stored byte it touches, skipped bytes included, one byte per step;
// a zero-bit read or a read of an empty store goes straight to its result.
// Every result passes through the output register before it is shown.
// One item is in work at a time.
// Reset clears the indices, the fill count and the bit position; the store
// contents are not cleared, and the block accepts words right after reset.
// The result waits in an output register while the receiver stalls; the
// next word is accepted meanwhile and its result is held until the output
// register is free.
// ---------------------------------------------------------------------------
module jpeg_bit_reader_unstuffing
  import jbr_pkg::*;
#(
  parameter int BUFFER_BYTES  = 4096,
  parameter int MAX_READ_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic [COUNT_W-1:0] in_bit_count,
  input  logic               in_discard_stuffing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VALUE_W-1:0] out_value,
  output logic [COUNT_W-1:0] out_bits_read,
  output logic               out_load_dropped,
  output logic               out_stream_empty
);

  localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int HW = $clog2(BUFFER_BYTES + 1);

  jbr_item_t         item;
  jbr_result_t       res;
  jbr_result_t       out_r;
  logic              out_valid_r;
  logic              res_valid;
  logic              res_take;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [BYTE_W-1:0] mem_wr_data;
  logic [AW-1:0]     mem_rd_addr;
  logic [BYTE_W-1:0] mem_rd_data;

  assign item.command          = in_command;
  assign item.data_byte        = in_data_byte;
  assign item.bit_count        = in_bit_count;
  assign item.discard_stuffing = in_discard_stuffing;

  assign res_take = !out_valid_r || out_ready;

  jbr_store #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  jbr_seq #(
    .BUFFER_BYTES  (BUFFER_BYTES),
    .MAX_READ_BITS (MAX_READ_BITS),
    .AW            (AW),
    .HW            (HW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .item        (item),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
    if (res_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_r.value;
  assign out_bits_read    = out_r.bits_read;
  assign out_load_dropped = out_r.load_dropped;
  assign out_stream_empty = out_r.stream_empty;

endmodule
